FILE: rtl/llrb_pkg.sv
`default_nettype none
package llrb_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int LINE_CHARS_DEF = 32;
  localparam int CPUS_DEF       = 8;

  localparam int          LEN_W      = 7;
  localparam int          NLEVELS    = 5;
  localparam logic [2:0]  LEVEL_INFO = 3'd3;
  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_RETURN  = 8'd13;
  localparam logic [47:0] SEQ_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] DROP_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_FLUSH = 2'd1,
    OP_READ  = 2'd2,
    OP_STAT  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    SEL_RECORDS     = 4'd0,
    SEL_OVERWRITTEN = 4'd1,
    SEL_TRUNC_LINES = 4'd2,
    SEL_TRUNC_CHARS = 4'd3,
    SEL_LEVEL0      = 4'd4,
    SEL_LEVEL1      = 4'd5,
    SEL_LEVEL2      = 4'd6,
    SEL_LEVEL3      = 4'd7,
    SEL_LEVEL4      = 4'd8,
    SEL_NEXT_SEQ    = 4'd9,
    SEL_FIRST_SEQ   = 4'd10
  } sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LUPD,
    ST_COPY,
    ST_COMMIT,
    ST_RCHK,
    ST_RSLOT,
    ST_RMREAD,
    ST_RMETA,
    ST_ROUT,
    ST_RWAIT,
    ST_STAT,
    ST_SOUT
  } state_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [31:0]      dropped;
    logic [2:0]       level;
  } line_meta_t;

  typedef struct packed {
    logic [31:0]      ms;
    logic [31:0]      dropped;
    logic [LEN_W-1:0] len;
    logic [2:0]       level;
    logic [2:0]       cpu;
  } slot_meta_t;

  typedef struct packed {
    logic load;
    logic lupd;
    logic copy;
    logic commit;
    logic rchk;
    logic rslot;
    logic meta_rd;
    logic text_rd;
    logic k_inc;
    logic stat;
    logic show_rec;
  } cmd_t;

  typedef struct packed {
    logic commit;
    logic copy_done;
    logic found;
    logic last;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/llrb_ctrl.sv
`default_nettype none
module llrb_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [1:0]        operation_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  input  llrb_pkg::sts_t    sts_i,
  output llrb_pkg::cmd_t    cmd_o
);

  llrb_pkg::state_e state_q, state_d;
  logic in_acc;

  assign in_acc = in_valid_i && (state_q == llrb_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llrb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      llrb_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (llrb_pkg::op_e'(operation_i))
            llrb_pkg::OP_PUT, llrb_pkg::OP_FLUSH: state_d = llrb_pkg::ST_LUPD;
            llrb_pkg::OP_READ:                    state_d = llrb_pkg::ST_RCHK;
            default:                              state_d = llrb_pkg::ST_STAT;
          endcase
        end
      end
      llrb_pkg::ST_LUPD:   state_d = sts_i.commit ? llrb_pkg::ST_COPY : llrb_pkg::ST_IDLE;
      llrb_pkg::ST_COPY:   state_d = sts_i.copy_done ? llrb_pkg::ST_COMMIT : llrb_pkg::ST_COPY;
      llrb_pkg::ST_COMMIT: state_d = llrb_pkg::ST_IDLE;
      llrb_pkg::ST_RCHK:   state_d = llrb_pkg::ST_RSLOT;
      llrb_pkg::ST_RSLOT:  state_d = sts_i.found ? llrb_pkg::ST_RMREAD : llrb_pkg::ST_SOUT;
      llrb_pkg::ST_RMREAD: state_d = llrb_pkg::ST_RMETA;
      llrb_pkg::ST_RMETA:  state_d = llrb_pkg::ST_ROUT;
      llrb_pkg::ST_ROUT: begin
        if (!out_stall_i) begin
          state_d = sts_i.last ? llrb_pkg::ST_IDLE : llrb_pkg::ST_RWAIT;
        end
      end
      llrb_pkg::ST_RWAIT:  state_d = llrb_pkg::ST_ROUT;
      llrb_pkg::ST_STAT:   state_d = llrb_pkg::ST_SOUT;
      llrb_pkg::ST_SOUT: begin
        if (!out_stall_i) begin
          state_d = llrb_pkg::ST_IDLE;
        end
      end
      default: state_d = llrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_acc;
    cmd_o.lupd     = (state_q == llrb_pkg::ST_LUPD);
    cmd_o.copy     = (state_q == llrb_pkg::ST_COPY);
    cmd_o.commit   = (state_q == llrb_pkg::ST_COMMIT);
    cmd_o.rchk     = (state_q == llrb_pkg::ST_RCHK);
    cmd_o.rslot    = (state_q == llrb_pkg::ST_RSLOT);
    cmd_o.meta_rd  = (state_q == llrb_pkg::ST_RMREAD);
    cmd_o.text_rd  = (state_q == llrb_pkg::ST_RMETA) || (state_q == llrb_pkg::ST_RWAIT);
    cmd_o.k_inc    = (state_q == llrb_pkg::ST_ROUT) && !out_stall_i && !sts_i.last;
    cmd_o.stat     = (state_q == llrb_pkg::ST_STAT);
    cmd_o.show_rec = (state_q == llrb_pkg::ST_ROUT);
    in_stall_o     = (state_q != llrb_pkg::ST_IDLE);
    out_valid_o    = (state_q == llrb_pkg::ST_ROUT) || (state_q == llrb_pkg::ST_SOUT);
  end

endmodule
`default_nettype wire

FILE: rtl/llrb_dpath.sv
`default_nettype none
module llrb_dpath #(
  parameter int SLOTS      = llrb_pkg::SLOTS_DEF,
  parameter int LINE_CHARS = llrb_pkg::LINE_CHARS_DEF,
  parameter int CPUS       = llrb_pkg::CPUS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  llrb_pkg::cmd_t    cmd_i,
  output llrb_pkg::sts_t    sts_o,
  input  wire  [1:0]        operation_i,
  input  wire  [2:0]        cpu_id_i,
  input  wire  [2:0]        severity_i,
  input  wire  [7:0]        char_in_i,
  input  wire  [31:0]       now_ms_i,
  input  wire  [47:0]       query_seq_i,
  input  wire  [3:0]        stat_select_i,
  output logic              found_o,
  output logic [47:0]       record_seq_o,
  output logic [31:0]       record_ms_o,
  output logic [2:0]        record_level_o,
  output logic [2:0]        record_cpu_o,
  output logic [5:0]        record_len_o,
  output logic [31:0]       record_dropped_o,
  output logic [7:0]        text_char_o,
  output logic [47:0]       stat_value_o,
  output logic              last_o
);

  localparam int CW     = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int TW     = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam int SW     = $clog2(SLOTS);
  localparam int LDEPTH = CPUS << TW;
  localparam int SDEPTH = SLOTS << TW;
  localparam logic [llrb_pkg::LEN_W-1:0] TMAX = llrb_pkg::LEN_W'(LINE_CHARS);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
  localparam logic [47:0]   SLOTS48   = 48'(SLOTS);

  // item fields
  logic [1:0]    op_q;
  logic [CW-1:0] cpu_q;
  logic [2:0]    cpu3_q;
  logic [2:0]    sev_q;
  logic [7:0]    ch_q;
  logic [31:0]   ms_q;
  logic [47:0]   seq_q;
  logic [3:0]    sel_q;

  // per-CPU line state, a clear valid bit per CPU stands for the cleared line
  llrb_pkg::line_meta_t line_mem [CPUS];
  logic [CPUS-1:0]      line_vld_q;
  llrb_pkg::line_meta_t lm_rd_q;
  logic                 lv_rd_q;
  logic [7:0]           line_text [LDEPTH];
  logic [7:0]           lt_rd_q;

  // record store
  llrb_pkg::slot_meta_t slot_mem [SLOTS];
  llrb_pkg::slot_meta_t sm_rd_q;
  logic [7:0]           slot_text [SDEPTH];
  logic [7:0]           stx_rd_q;

  // global counters
  logic [47:0] next_q;
  logic [SW-1:0] slot_ptr_q;
  logic [47:0] trunc_lines_q;
  logic [47:0] trunc_chars_q;
  logic [47:0] lvl_cnt_q [llrb_pkg::NLEVELS];

  // commit staging
  logic [llrb_pkg::LEN_W-1:0] c_len_q;
  logic [31:0]                c_drop_q;
  logic [2:0]                 c_lvl_q;
  logic [llrb_pkg::LEN_W-1:0] cnt_q;
  logic [llrb_pkg::LEN_W-1:0] widx_q;
  logic                       pend_q;

  // read path
  logic          found_q;
  logic [SW-1:0] age_q;
  logic [SW-1:0] slot_q;
  logic [llrb_pkg::LEN_W-1:0] k_q;
  logic [47:0]   stat_q;

  logic [8:0]    cpu_ext;
  logic          cpu_ok;
  logic [CW-1:0] cpu_in;

  assign cpu_ext = {6'd0, cpu_id_i};
  assign cpu_ok  = cpu_ext < 9'(CPUS);
  assign cpu_in  = cpu_ok ? cpu_ext[CW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      cpu_q   <= cpu_in;
      cpu3_q  <= cpu_ok ? cpu_id_i : 3'd0;
      sev_q   <= severity_i;
      ch_q    <= char_in_i;
      ms_q    <= now_ms_i;
      seq_q   <= query_seq_i;
      sel_q   <= stat_select_i;
      lm_rd_q <= line_mem[cpu_in];
      lv_rd_q <= line_vld_q[cpu_in];
    end
  end

  // line update
  llrb_pkg::line_meta_t cur, lm_wd;
  logic       lm_we, lt_we, is_put, empty, commit_want;
  logic       vld_set, vld_clr;
  logic [2:0] lvl_new;

  always_comb begin
    cur = lv_rd_q ? lm_rd_q
                  : llrb_pkg::line_meta_t'{len: '0, dropped: '0, level: llrb_pkg::LEVEL_INFO};
    is_put = (llrb_pkg::op_e'(op_q) == llrb_pkg::OP_PUT);
    empty  = (cur.len == '0) && (cur.dropped == '0);
    lvl_new = cur.level;
    if (is_put && (sev_q < 3'(llrb_pkg::NLEVELS)) && (empty || (sev_q < cur.level))) begin
      lvl_new = sev_q;
    end
    commit_want = is_put ? ((ch_q == llrb_pkg::CH_NEWLINE) && !empty) : !empty;
    lm_we   = 1'b0;
    lt_we   = 1'b0;
    vld_set = 1'b0;
    vld_clr = 1'b0;
    lm_wd   = '{len: cur.len, dropped: cur.dropped, level: lvl_new};
    if (cmd_i.lupd) begin
      if (is_put) begin
        priority if (ch_q == llrb_pkg::CH_NEWLINE) begin
          vld_clr = 1'b1;
        end else if (ch_q == llrb_pkg::CH_RETURN) begin
          lm_we = 1'b1;
        end else if (cur.len < TMAX) begin
          lt_we     = 1'b1;
          lm_we     = 1'b1;
          lm_wd.len = cur.len + 1'b1;
        end else begin
          lm_we = 1'b1;
          if (cur.dropped != llrb_pkg::DROP_MAX) begin
            lm_wd.dropped = cur.dropped + 32'd1;
          end
        end
        vld_set = lm_we;
      end else if (!empty) begin
        vld_clr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lm_we) begin
      line_mem[cpu_q] <= lm_wd;
    end
    if (lt_we) begin
      line_text[{cpu_q, cur.len[TW-1:0]}] <= ch_q;
    end
    if (cmd_i.copy && (cnt_q < c_len_q)) begin
      lt_rd_q <= line_text[{cpu_q, cnt_q[TW-1:0]}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_vld_q <= '0;
    end else if (vld_set) begin
      line_vld_q[cpu_q] <= 1'b1;
    end else if (vld_clr) begin
      line_vld_q[cpu_q] <= 1'b0;
    end
  end

  // copy sequencer
  always_ff @(posedge clk_i) begin
    if (cmd_i.lupd) begin
      c_len_q  <= cur.len;
      c_drop_q <= cur.dropped;
      c_lvl_q  <= lvl_new;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
    end else if (cmd_i.copy) begin
      pend_q <= cnt_q < c_len_q;
      widx_q <= cnt_q;
      if (cnt_q < c_len_q) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy && pend_q) begin
      slot_text[{slot_ptr_q, widx_q[TW-1:0]}] <= lt_rd_q;
    end
    if (cmd_i.commit) begin
      slot_mem[slot_ptr_q] <= '{ms: ms_q, dropped: c_drop_q, len: c_len_q,
                                level: c_lvl_q, cpu: cpu3_q};
    end
    if (cmd_i.meta_rd) begin
      sm_rd_q <= slot_mem[slot_q];
    end
    if (cmd_i.text_rd) begin
      stx_rd_q <= slot_text[{slot_q, k_q[TW-1:0]}];
    end
  end

  // global counters
  logic [48:0] chars_sum;
  assign chars_sum = {1'b0, trunc_chars_q} + 49'(c_drop_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q        <= 48'd1;
      slot_ptr_q    <= SW'(1);
      trunc_lines_q <= '0;
      trunc_chars_q <= '0;
      for (int i = 0; i < llrb_pkg::NLEVELS; i++) begin
        lvl_cnt_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      next_q     <= next_q + 48'd1;
      slot_ptr_q <= (slot_ptr_q == SLOT_LAST) ? '0 : slot_ptr_q + 1'b1;
      for (int i = 0; i < llrb_pkg::NLEVELS; i++) begin
        if ((c_lvl_q == 3'(i)) && (lvl_cnt_q[i] != llrb_pkg::SEQ_MAX)) begin
          lvl_cnt_q[i] <= lvl_cnt_q[i] + 48'd1;
        end
      end
      if (c_drop_q != '0) begin
        if (trunc_lines_q != llrb_pkg::SEQ_MAX) begin
          trunc_lines_q <= trunc_lines_q + 48'd1;
        end
        trunc_chars_q <= chars_sum[48] ? llrb_pkg::SEQ_MAX : chars_sum[47:0];
      end
    end
  end

  // record lookup: a sequence is present while it lies in the last SLOTS commits
  logic [47:0]   age;
  logic [SW-1:0] last_slot;
  logic [SW:0]   slot_wrap;
  logic [47:0]   n_rec;
  logic [47:0]   stat_val;

  assign age       = next_q - 48'd1 - seq_q;
  assign last_slot = (slot_ptr_q == '0) ? SLOT_LAST : slot_ptr_q - 1'b1;
  assign slot_wrap = {1'b0, last_slot} + (SW + 1)'(SLOTS) - {1'b0, age_q};
  assign n_rec     = next_q - 48'd1;

  always_comb begin
    unique case (sel_q)
      llrb_pkg::SEL_RECORDS:     stat_val = n_rec;
      llrb_pkg::SEL_OVERWRITTEN: stat_val = (n_rec > SLOTS48) ? n_rec - SLOTS48 : '0;
      llrb_pkg::SEL_TRUNC_LINES: stat_val = trunc_lines_q;
      llrb_pkg::SEL_TRUNC_CHARS: stat_val = trunc_chars_q;
      llrb_pkg::SEL_LEVEL0:      stat_val = lvl_cnt_q[0];
      llrb_pkg::SEL_LEVEL1:      stat_val = lvl_cnt_q[1];
      llrb_pkg::SEL_LEVEL2:      stat_val = lvl_cnt_q[2];
      llrb_pkg::SEL_LEVEL3:      stat_val = lvl_cnt_q[3];
      llrb_pkg::SEL_LEVEL4:      stat_val = lvl_cnt_q[4];
      llrb_pkg::SEL_NEXT_SEQ:    stat_val = next_q;
      llrb_pkg::SEL_FIRST_SEQ:   stat_val = (next_q > SLOTS48) ? next_q - SLOTS48 : 48'd1;
      default:                   stat_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.rchk) begin
      found_q <= (seq_q != '0) && (seq_q < next_q) && (age < SLOTS48);
      age_q   <= age[SW-1:0];
      stat_q  <= '0;
    end
    if (cmd_i.rslot) begin
      slot_q <= (last_slot >= age_q) ? last_slot - age_q : slot_wrap[SW-1:0];
    end
    if (cmd_i.stat) begin
      stat_q <= stat_val;
    end
  end

  logic rec_last;
  assign rec_last = (sm_rd_q.len == '0) || (k_q == sm_rd_q.len - 1'b1);

  always_comb begin
    sts_o.commit    = commit_want && (next_q != llrb_pkg::SEQ_MAX);
    sts_o.copy_done = pend_q && (cnt_q == c_len_q);
    sts_o.found     = found_q;
    sts_o.last      = rec_last;
  end

  always_comb begin
    found_o          = cmd_i.show_rec;
    record_seq_o     = cmd_i.show_rec ? seq_q : '0;
    record_ms_o      = cmd_i.show_rec ? sm_rd_q.ms : '0;
    record_level_o   = cmd_i.show_rec ? sm_rd_q.level : '0;
    record_cpu_o     = cmd_i.show_rec ? sm_rd_q.cpu : '0;
    record_len_o     = cmd_i.show_rec ? sm_rd_q.len[5:0] : '0;
    record_dropped_o = cmd_i.show_rec ? sm_rd_q.dropped : '0;
    text_char_o      = (cmd_i.show_rec && (sm_rd_q.len != '0)) ? stx_rd_q : '0;
    stat_value_o     = cmd_i.show_rec ? '0 : stat_q;
    last_o           = cmd_i.show_rec ? rec_last : 1'b1;
  end

endmodule
`default_nettype wire

FILE: rtl/log_line_ring_buffer_unit.sv
`default_nettype none
// Sequenced log ring buffer. Put-character items build one line per CPU; a
// newline or a flush commits the line as a record with the next sequence number
// into slot seq mod SLOTS. Read-record items return one item per stored text
// character (one item for an empty or missing record), read-counter items return
// one item. One item is worked on at a time and in_stall_o stays high until all of
// its results are taken. The controller sequence and the one-port text memories
// set the timing: a commit copies one text character per cycle, and a found
// record fetches each text character after the first in a wait state between
// its results. Each result is held while out_stall_i is high. No clearing pass
// is needed after reset: presence of a record follows from the sequence
// counter, and per-CPU lines carry valid bits.
module log_line_ring_buffer_unit #(
  parameter int SLOTS      = llrb_pkg::SLOTS_DEF,
  parameter int LINE_CHARS = llrb_pkg::LINE_CHARS_DEF,
  parameter int CPUS       = llrb_pkg::CPUS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  operation_i,
  input  wire  [2:0]  cpu_id_i,
  input  wire  [2:0]  severity_i,
  input  wire  [7:0]  char_in_i,
  input  wire  [31:0] now_ms_i,
  input  wire  [47:0] query_seq_i,
  input  wire  [3:0]  stat_select_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        found_o,
  output logic [47:0] record_seq_o,
  output logic [31:0] record_ms_o,
  output logic [2:0]  record_level_o,
  output logic [2:0]  record_cpu_o,
  output logic [5:0]  record_len_o,
  output logic [31:0] record_dropped_o,
  output logic [7:0]  text_char_o,
  output logic [47:0] stat_value_o,
  output logic        last_o
);

  llrb_pkg::cmd_t cmd;
  llrb_pkg::sts_t sts;

  // sequence the item: line update, text copy, commit, or record/counter read
  llrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // hold line state, record store and counters
  llrb_dpath #(
    .SLOTS      (SLOTS),
    .LINE_CHARS (LINE_CHARS),
    .CPUS       (CPUS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .cpu_id_i         (cpu_id_i),
    .severity_i       (severity_i),
    .char_in_i        (char_in_i),
    .now_ms_i         (now_ms_i),
    .query_seq_i      (query_seq_i),
    .stat_select_i    (stat_select_i),
    .found_o          (found_o),
    .record_seq_o     (record_seq_o),
    .record_ms_o      (record_ms_o),
    .record_level_o   (record_level_o),
    .record_cpu_o     (record_cpu_o),
    .record_len_o     (record_len_o),
    .record_dropped_o (record_dropped_o),
    .text_char_o      (text_char_o),
    .stat_value_o     (stat_value_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

FILE: rtl/llrb_checker.sv
`default_nettype none
module llrb_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire        found_o,
  input wire [7:0]  text_char_o,
  input wire        last_o
);

  // accepted item stalls the input in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice in a row");

  // no new item while a result is pending
  a_stall_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // multi-result items are only found records
  a_multi_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> found_o)
    else $error("non-final result without record");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(text_char_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind log_line_ring_buffer_unit llrb_checker u_llrb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .found_o     (found_o),
  .text_char_o (text_char_o),
  .last_o      (last_o)
);
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    llrb_pkg::op_e op;
    logic [2:0]    cpu;
    logic [2:0]    sev;
    logic [7:0]    ch;
    logic [31:0]   ms;
    logic [47:0]   q;
    logic [3:0]    sel;
  } log_item_t;

  typedef struct {
    logic        found;
    logic [47:0] seq;
    logic [31:0] ms;
    logic [2:0]  level;
    logic [2:0]  cpu;
    logic [5:0]  len;
    logic [31:0] dropped;
    logic [7:0]  ch;
    logic [47:0] stat;
    logic        last;
  } log_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  // DUT input side; every input port starts from a known value
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [2:0]  cpu_id = '0;
  logic [2:0]  severity = '0;
  logic [7:0]  char_in = '0;
  logic [31:0] now_ms = '0;
  logic [47:0] query_seq = '0;
  logic [3:0]  stat_select = '0;

  // DUT output side
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [47:0] record_seq;
  logic [31:0] record_ms;
  logic [2:0]  record_level;
  logic [2:0]  record_cpu;
  logic [5:0]  record_len;
  logic [31:0] record_dropped;
  logic [7:0]  text_char;
  logic [47:0] stat_value;
  logic        last;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  log_line_ring_buffer_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .cpu_id_i        (cpu_id),
    .severity_i      (severity),
    .char_in_i       (char_in),
    .now_ms_i        (now_ms),
    .query_seq_i     (query_seq),
    .stat_select_i   (stat_select),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .found_o         (found),
    .record_seq_o    (record_seq),
    .record_ms_o     (record_ms),
    .record_level_o  (record_level),
    .record_cpu_o    (record_cpu),
    .record_len_o    (record_len),
    .record_dropped_o(record_dropped),
    .text_char_o     (text_char),
    .stat_value_o    (stat_value),
    .last_o          (last)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the log buffer: per-CPU lines, ring slots and counters.
  // ---------------------------------------------------------------------------
  logic [5:0]  ln_len  [llrb_pkg::CPUS_DEF];
  logic [31:0] ln_drop [llrb_pkg::CPUS_DEF];
  logic [2:0]  ln_lvl  [llrb_pkg::CPUS_DEF];
  logic [7:0]  ln_text [llrb_pkg::CPUS_DEF][llrb_pkg::LINE_CHARS_DEF];

  logic [47:0] sl_seq  [llrb_pkg::SLOTS_DEF];
  logic [31:0] sl_ms   [llrb_pkg::SLOTS_DEF];
  logic [31:0] sl_drop [llrb_pkg::SLOTS_DEF];
  logic [5:0]  sl_len  [llrb_pkg::SLOTS_DEF];
  logic [2:0]  sl_lvl  [llrb_pkg::SLOTS_DEF];
  logic [2:0]  sl_cpu  [llrb_pkg::SLOTS_DEF];
  logic [7:0]  sl_text [llrb_pkg::SLOTS_DEF][llrb_pkg::LINE_CHARS_DEF];

  logic [47:0] next_seq;
  logic [47:0] trunc_lines;
  logic [47:0] trunc_chars;
  logic [47:0] level_cnt [llrb_pkg::NLEVELS];

  log_row_t  pending_rows[$];
  log_item_t stim_items[$];

  int commits_seen = 0;
  int rows_checked = 0;
  int errors = 0;

  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? llrb_pkg::SEQ_MAX : s[47:0];
  endfunction

  function automatic void line_clear(int c);
    ln_len[c]  = '0;
    ln_drop[c] = '0;
    ln_lvl[c]  = llrb_pkg::LEVEL_INFO;
  endfunction

  function automatic void shadow_reset();
    for (int c = 0; c < llrb_pkg::CPUS_DEF; c++) line_clear(c);
    for (int s = 0; s < llrb_pkg::SLOTS_DEF; s++) sl_seq[s] = '0;
    next_seq    = 48'd1;
    trunc_lines = '0;
    trunc_chars = '0;
    for (int l = 0; l < llrb_pkg::NLEVELS; l++) level_cnt[l] = '0;
  endfunction

  function automatic void line_commit(int c, logic [31:0] ms);
    int s;
    if (next_seq >= llrb_pkg::SEQ_MAX) return;
    s = int'(next_seq[5:0]);
    sl_seq[s]  = next_seq;
    sl_ms[s]   = ms;
    sl_drop[s] = ln_drop[c];
    sl_len[s]  = ln_len[c];
    sl_lvl[s]  = ln_lvl[c];
    sl_cpu[s]  = 3'(c);
    for (int i = 0; i < ln_len[c]; i++) sl_text[s][i] = ln_text[c][i];
    next_seq = next_seq + 48'd1;
    commits_seen++;
    if (ln_lvl[c] < llrb_pkg::NLEVELS)
      level_cnt[ln_lvl[c]] = sat_add48(level_cnt[ln_lvl[c]], 48'd1);
    if (ln_drop[c] != 0) begin
      trunc_lines = sat_add48(trunc_lines, 48'd1);
      trunc_chars = sat_add48(trunc_chars, {16'd0, ln_drop[c]});
    end
  endfunction

  // Advance the shadow by one accepted item and queue the rows it must produce.
  function automatic void predict_log_item(log_item_t it);
    log_row_t    r;
    int          c;
    int          s;
    logic [47:0] n;
    c = int'(it.cpu);
    r = '{default: '0};
    case (it.op)
      llrb_pkg::OP_PUT: begin
        if (it.sev < llrb_pkg::NLEVELS) begin
          if (ln_len[c] == 0 && ln_drop[c] == 0) ln_lvl[c] = it.sev;
          else if (it.sev < ln_lvl[c]) ln_lvl[c] = it.sev;
        end
        if (it.ch == llrb_pkg::CH_NEWLINE) begin
          if (ln_len[c] != 0 || ln_drop[c] != 0) line_commit(c, it.ms);
          line_clear(c);
        end else if (it.ch == llrb_pkg::CH_RETURN) begin
          // swallowed
        end else if (ln_len[c] < llrb_pkg::LINE_CHARS_DEF) begin
          ln_text[c][ln_len[c]] = it.ch;
          ln_len[c] = ln_len[c] + 6'd1;
        end else if (ln_drop[c] != llrb_pkg::DROP_MAX) begin
          ln_drop[c] = ln_drop[c] + 32'd1;
        end
      end
      llrb_pkg::OP_FLUSH: begin
        if (ln_len[c] != 0 || ln_drop[c] != 0) begin
          line_commit(c, it.ms);
          line_clear(c);
        end
      end
      llrb_pkg::OP_READ: begin
        s = int'(it.q[5:0]);
        if (it.q == 0 || it.q >= next_seq || sl_seq[s] != it.q) begin
          r.last = 1'b1;
          pending_rows.push_back(r);
        end else begin
          r.found   = 1'b1;
          r.seq     = it.q;
          r.ms      = sl_ms[s];
          r.level   = sl_lvl[s];
          r.cpu     = sl_cpu[s];
          r.len     = sl_len[s];
          r.dropped = sl_drop[s];
          if (sl_len[s] == 0) begin
            r.last = 1'b1;
            pending_rows.push_back(r);
          end
          for (int i = 0; i < sl_len[s]; i++) begin
            r.ch   = sl_text[s][i];
            r.last = (i + 1 == sl_len[s]);
            pending_rows.push_back(r);
          end
        end
      end
      default: begin
        n = next_seq - 48'd1;
        case (llrb_pkg::sel_e'(it.sel))
          llrb_pkg::SEL_RECORDS:     r.stat = n;
          llrb_pkg::SEL_OVERWRITTEN:
            r.stat = (n > llrb_pkg::SLOTS_DEF) ? n - llrb_pkg::SLOTS_DEF : '0;
          llrb_pkg::SEL_TRUNC_LINES: r.stat = trunc_lines;
          llrb_pkg::SEL_TRUNC_CHARS: r.stat = trunc_chars;
          llrb_pkg::SEL_LEVEL0:      r.stat = level_cnt[0];
          llrb_pkg::SEL_LEVEL1:      r.stat = level_cnt[1];
          llrb_pkg::SEL_LEVEL2:      r.stat = level_cnt[2];
          llrb_pkg::SEL_LEVEL3:      r.stat = level_cnt[3];
          llrb_pkg::SEL_LEVEL4:      r.stat = level_cnt[4];
          llrb_pkg::SEL_NEXT_SEQ:    r.stat = next_seq;
          llrb_pkg::SEL_FIRST_SEQ:
            r.stat = (next_seq > llrb_pkg::SLOTS_DEF) ? next_seq - llrb_pkg::SLOTS_DEF
                                                      : 48'd1;
          default:                   r.stat = '0;
        endcase
        r.last = 1'b1;
        pending_rows.push_back(r);
      end
    endcase
  endfunction

  function automatic void field_check(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_item(llrb_pkg::op_e op, int c, int sev, int ch,
                                   logic [47:0] q, int sel);
    log_item_t it;
    it.op  = op;
    it.cpu = 3'(c);
    it.sev = 3'(sev);
    it.ch  = 8'(ch);
    it.ms  = $urandom;
    it.q   = q;
    it.sel = 4'(sel);
    stim_items.push_back(it);
  endfunction

  // Pick a random text byte, keeping newline and carriage return out.
  function automatic int text_byte();
    int b;
    b = $urandom_range(0, 255);
    if (b == llrb_pkg::CH_NEWLINE || b == llrb_pkg::CH_RETURN) b = b + 1;
    return b;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present items at the falling edge, hold them while stalled.
  // ---------------------------------------------------------------------------
  log_item_t cur_item;
  logic      in_taken = 1'b0;
  int        in_gap = 0;
  int        out_hold = 0;
  logic      calm = 1'b0;

  always @(negedge clk) begin
    log_item_t nx;
    logic      nv;
    if (rst_ni) begin
      nv = in_valid;
      if (in_taken) begin
        in_taken = 1'b0;
        in_gap   = calm ? 0 : pick_gap();
        nv       = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (stim_items.size() > 0) begin
          nx = stim_items.pop_front();
          cur_item    = nx;
          operation   <= nx.op;
          cpu_id      <= nx.cpu;
          severity    <= nx.sev;
          char_in     <= nx.ch;
          now_ms      <= nx.ms;
          query_seq   <= nx.q;
          stat_select <= nx.sel;
          nv = 1'b1;
        end
      end
      in_valid <= nv;

      // Receiver stall: mostly free-running, sometimes a long hold-off.
      if ($urandom_range(0, 299) == 0) calm = ~calm;
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample handshakes at the rising edge, check rows, then predict.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    log_row_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_rows.size() == 0) begin
          $display("%0t: unexpected result row, expected none, got seq %0h char %0h stat %0h",
                   $realtime, record_seq, text_char, stat_value);
          errors++;
        end else begin
          e = pending_rows.pop_front();
          rows_checked++;
          field_check("found", 48'(e.found), 48'(found));
          field_check("record_seq", e.seq, record_seq);
          field_check("record_ms", 48'(e.ms), 48'(record_ms));
          field_check("record_level", 48'(e.level), 48'(record_level));
          field_check("record_cpu", 48'(e.cpu), 48'(record_cpu));
          field_check("record_len", 48'(e.len), 48'(record_len));
          field_check("record_dropped", 48'(e.dropped), 48'(record_dropped));
          field_check("text_char", 48'(e.ch), 48'(text_char));
          field_check("stat_value", e.stat, stat_value);
          field_check("last", 48'(e.last), 48'(last));
        end
      end
      if (in_valid && !in_stall) begin
        predict_log_item(cur_item);
        in_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed corner cases, then random line traffic.
  // ---------------------------------------------------------------------------
  initial begin
    int c;
    int n;
    int r;
    int line_len;
    shadow_reset();

    // Counters on an empty buffer, including an unknown select.
    add_item(llrb_pkg::OP_STAT, 0, 0, 0, '0, llrb_pkg::SEL_FIRST_SEQ);
    add_item(llrb_pkg::OP_STAT, 0, 0, 0, '0, llrb_pkg::SEL_NEXT_SEQ);
    add_item(llrb_pkg::OP_STAT, 7, 7, 255, llrb_pkg::SEQ_MAX, 15);
    // Read with sequence zero and with the largest sequence.
    add_item(llrb_pkg::OP_READ, 0, 0, 0, '0, 0);
    add_item(llrb_pkg::OP_READ, 0, 0, 0, llrb_pkg::SEQ_MAX, 0);
    // Flush and newline on an empty line: nothing committed.
    add_item(llrb_pkg::OP_FLUSH, 3, 0, 0, '0, 0);
    add_item(llrb_pkg::OP_PUT, 2, 0, llrb_pkg::CH_NEWLINE, '0, 0);
    // A line on CPU 1: level from the first character, control characters
    // still raise severity, extreme bytes and ignored levels.
    add_item(llrb_pkg::OP_PUT, 1, 4, 0, '0, 0);
    add_item(llrb_pkg::OP_PUT, 1, 7, 255, '0, 0);
    add_item(llrb_pkg::OP_PUT, 1, 4, llrb_pkg::CH_RETURN, '0, 0);
    add_item(llrb_pkg::OP_PUT, 1, 1, llrb_pkg::CH_NEWLINE, '0, 0);
    // A line on CPU 7 committed by flush, then read back both records and one beyond.
    add_item(llrb_pkg::OP_PUT, 7, 5, 65, '0, 0);
    add_item(llrb_pkg::OP_PUT, 7, 0, 66, '0, 0);
    add_item(llrb_pkg::OP_FLUSH, 7, 0, 0, '0, 0);
    add_item(llrb_pkg::OP_READ, 0, 0, 0, 48'd1, 0);
    add_item(llrb_pkg::OP_READ, 0, 0, 0, 48'd2, 0);
    add_item(llrb_pkg::OP_READ, 0, 0, 0, 48'd3, 0);
    // An overlong line: the tail beyond the text limit is counted as dropped.
    for (int i = 0; i < llrb_pkg::LINE_CHARS_DEF + 3; i++)
      add_item(llrb_pkg::OP_PUT, 4, 2, text_byte(), '0, 0);
    add_item(llrb_pkg::OP_PUT, 4, 7, llrb_pkg::CH_NEWLINE, '0, 0);
    add_item(llrb_pkg::OP_READ, 0, 0, 0, 48'd3, 0);
    add_item(llrb_pkg::OP_STAT, 0, 0, 0, '0, llrb_pkg::SEL_TRUNC_CHARS);
    add_item(llrb_pkg::OP_STAT, 0, 0, 0, '0, llrb_pkg::SEL_LEVEL1);

    // Random part: mostly whole lines with random content, plus reads, counter
    // reads and stray items.
    n = 0;
    while (n < 290) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        c = $urandom_range(0, 7);
        case ($urandom_range(0, 9))
          0:       line_len = 0;
          9:       line_len = $urandom_range(llrb_pkg::LINE_CHARS_DEF - 2,
                                             llrb_pkg::LINE_CHARS_DEF + 6);
          default: line_len = $urandom_range(1, 4);
        endcase
        for (int i = 0; i < line_len; i++) begin
          if ($urandom_range(0, 19) == 0)
            add_item(llrb_pkg::OP_PUT, c, $urandom_range(0, 7), llrb_pkg::CH_RETURN, '0, 0);
          else
            add_item(llrb_pkg::OP_PUT, c, $urandom_range(0, 7), text_byte(), '0, 0);
        end
        if ($urandom_range(0, 3) == 0)
          add_item(llrb_pkg::OP_FLUSH, c, $urandom_range(0, 7), $urandom_range(0, 255), '0, 0);
        else
          add_item(llrb_pkg::OP_PUT, c, $urandom_range(0, 7), llrb_pkg::CH_NEWLINE, '0, 0);
        n += line_len + 1;
      end else if (r < 78) begin
        if ($urandom_range(0, 7) == 0)
          add_item(llrb_pkg::OP_READ, $urandom_range(0, 7), 0, 0, 48'({$urandom, $urandom}), 0);
        else
          add_item(llrb_pkg::OP_READ, $urandom_range(0, 7), 0, 0,
                   48'(commits_estimate(stim_items.size()) + $urandom_range(0, 3)) -
                   48'($urandom_range(0, 70)), 0);
        n += 1;
      end else if (r < 90) begin
        add_item(llrb_pkg::OP_STAT, $urandom_range(0, 7), $urandom_range(0, 7), 0, '0,
                 $urandom_range(0, 15));
        n += 1;
      end else begin
        add_item(llrb_pkg::op_e'($urandom_range(0, 3)), $urandom_range(0, 7),
                 $urandom_range(0, 7), $urandom_range(0, 255), 48'({$urandom, $urandom}),
                 $urandom_range(0, 15));
        n += 1;
      end
    end
    for (int s = 0; s <= llrb_pkg::SEL_FIRST_SEQ; s++) add_item(llrb_pkg::OP_STAT, 0, 0, 0, '0, s);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    while (stim_items.size() > 0 || in_valid || pending_rows.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (pending_rows.size() > 0) begin
      $display("%0t: %0d expected rows never arrived", $realtime, pending_rows.size());
      errors++;
    end
    $display("Covered %0d committed lines through the ring and %0d checked result rows,",
             commits_seen, rows_checked);
    $display("with %0d truncated lines and %0d errors.", trunc_lines, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Rough guess of the sequence numbers in use, so reads mostly hit the ring.
  function automatic int commits_estimate(int queued);
    return queued / 6 + 1;
  endfunction

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
